### sv/midi_clock_nudge_filter_defines.svh
// assertion macros shared by the midi clock nudge filter modules
// no dependencies; included by files that carry concurrent assertions
`ifndef MIDI_CLOCK_NUDGE_FILTER_DEFINES_SVH
`define MIDI_CLOCK_NUDGE_FILTER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MCNF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define MCNF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/mcnf_pkg.sv
// types and constants of the midi clock nudge filter
// no dependencies; imported by every module of the block
`default_nettype none

package mcnf_pkg;

   localparam logic [7:0] MIDI_CLOCK    = 8'hf8;
   localparam logic [7:0] MIDI_START    = 8'hfa;
   localparam logic [7:0] MIDI_CONTINUE = 8'hfb;
   localparam logic [7:0] MIDI_STOP     = 8'hfc;

   // debounced key codes
   localparam logic [2:0] KEY_CONTINUE = 3'b001;
   localparam logic [2:0] KEY_SLIP     = 3'b010;
   localparam logic [2:0] KEY_CLOCK    = 3'b011;
   localparam logic [2:0] KEY_STOP     = 3'b100;
   localparam logic [2:0] KEY_START    = 3'b110;

   localparam logic [7:0] SLIP_MAX = 8'd255;

   localparam logic [7:0] DEBOUNCE_RESET    = 8'd20;
   localparam logic [7:0] LED_RUNNING_RESET = 8'd50;
   localparam logic [7:0] LED_STOPPED_RESET = 8'd1;
   localparam logic [6:0] TICKS_RESET       = 7'd24;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      REQ_RX   = 2'd0,
      REQ_KEY  = 2'd1,
      REQ_TICK = 2'd2,
      REQ_NONE = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      CSR_DEBOUNCE    = 2'd0,
      CSR_LED_RUNNING = 2'd1,
      CSR_LED_STOPPED = 2'd2,
      CSR_TICKS       = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_CLOCK,
      OP_START,
      OP_STOP,
      OP_CONT,
      OP_PASS,
      OP_KEY,
      OP_TICK
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  data;
   } op_entry_type;

   typedef struct packed {
      logic q_full;
      logic norm_busy;
   } front_hold_type;

endpackage

`default_nettype wire

### sv/midi_clock_nudge_filter.sv
// midi_clock_nudge_filter: midi pass-through that can hold back clock bytes
//
// req channel: one word per event. tuser gives the kind (received byte, key
// scan sample, millisecond tick); tdata carries the byte and the key lines.
// rsp channel: exactly one word per request word, in order. tuser is set
// when tdata[7:0] is a byte to transmit; tdata[8] is the beat led level.
// csr port: csr_we writes csr_wdata into the register selected by csr_addr
// (debounce, led hold running, led hold stopped, ticks per beat).
// A request word is written into the queue and its result into the result
// register; one word per cycle is sustained while the result side takes
// words and no beat count reduction runs. A two-entry queue sits between
// classify and execute, and the result register lets a new word be
// executed while the old one is taken. Writing ticks per beat starts a
// beat count reduction, one subtract per cycle, that holds req_tready low.
// Reset is synchronous; it restores the register defaults and clears all
// filter state and the queue. A stalled rsp side fills the queue, then
// drops req_tready; no word is lost.
`default_nettype none

module midi_clock_nudge_filter (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // rx_byte[7:0], key_lines[10:8]
   input  wire logic [1:0]  req_tuser,  // req_type
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,  // send_byte[7:0], led_on[8]
   output logic             rsp_tuser,  // send_valid
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [7:0]  csr_wdata
);
   import mcnf_pkg::*;

   front_hold_type hold;
   op_entry_type   push_entry;
   op_entry_type   q_entry;
   logic           push;
   logic           pop;
   logic           q_valid;
   logic           q_full;
   logic           norm_busy;

   assign hold.q_full    = q_full;
   assign hold.norm_busy = norm_busy;

   mcnf_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .hold       (hold),
      .push       (push),
      .push_entry (push_entry)
   );

   mcnf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .q_valid    (q_valid),
      .q_full     (q_full),
      .q_entry    (q_entry)
   );

   mcnf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .pop        (pop),
      .norm_busy  (norm_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

### sv/mcnf_front.sv
// front end: accepts request words and classifies them into operations
// depends on mcnf_pkg
`default_nettype none

module mcnf_front (
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [15:0]           req_tdata,  // rx_byte[7:0], key_lines[10:8]
   input  wire logic [1:0]            req_tuser,  // req_type
   input  wire mcnf_pkg::front_hold_type hold,
   output logic                       push,
   output mcnf_pkg::op_entry_type     push_entry
);
   import mcnf_pkg::*;

   logic [7:0] rx_byte;
   logic [2:0] key_lines;

   assign rx_byte    = req_tdata[7:0];
   assign key_lines  = req_tdata[10:8];
   assign req_tready = !hold.q_full && !hold.norm_busy;
   assign push       = req_tvalid && req_tready;

   always_comb begin
      push_entry.kind = OP_NONE;
      push_entry.data = 8'd0;
      unique case (req_kind_type'(req_tuser))
         REQ_RX: begin
            push_entry.data = rx_byte;
            unique case (rx_byte)
               MIDI_CLOCK:    push_entry.kind = OP_CLOCK;
               MIDI_START:    push_entry.kind = OP_START;
               MIDI_STOP:     push_entry.kind = OP_STOP;
               MIDI_CONTINUE: push_entry.kind = OP_CONT;
               default:       push_entry.kind = OP_PASS;
            endcase
         end
         REQ_KEY: begin
            push_entry.kind = OP_KEY;
            push_entry.data = {5'd0, key_lines};
         end
         REQ_TICK: push_entry.kind = OP_TICK;
         default:  push_entry.kind = OP_NONE;
      endcase
   end

endmodule

`default_nettype wire

### sv/mcnf_queue.sv
// short operation queue between the front end and the back end
// depends on mcnf_pkg and midi_clock_nudge_filter_defines.svh
`default_nettype none

`include "midi_clock_nudge_filter_defines.svh"

module mcnf_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire mcnf_pkg::op_entry_type push_entry,
   input  wire logic                  pop,
   output logic                       q_valid,
   output logic                       q_full,
   output mcnf_pkg::op_entry_type     q_entry
);
   import mcnf_pkg::*;

   op_entry_type       entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign q_valid = (count_ff != '0);
   assign q_full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_entry = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `MCNF_ASSERT_SAME(a_no_push_full, clock, reset, push, !q_full, "push into full queue")
   `MCNF_ASSERT_SAME(a_no_pop_empty, clock, reset, pop, q_valid, "pop from empty queue")

endmodule

`default_nettype wire

### sv/mcnf_back.sv
// back end: configuration registers, filter state, operation execution
// and the result register; depends on mcnf_pkg and the assertion macros
`default_nettype none

`include "midi_clock_nudge_filter_defines.svh"

module mcnf_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [1:0]            csr_addr,
   input  wire logic [7:0]            csr_wdata,
   input  wire logic                  q_valid,
   input  wire mcnf_pkg::op_entry_type q_entry,
   output logic                       pop,
   output logic                       norm_busy,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [15:0]                rsp_tdata,  // send_byte[7:0], led_on[8]
   output logic                       rsp_tuser   // send_valid
);
   import mcnf_pkg::*;

   logic [7:0] debounce_ms_ff, led_running_ms_ff, led_stopped_ms_ff;
   logic [6:0] ticks_ff;

   logic       running_ff, running_in;
   logic [7:0] slip_ff, slip_in;          // pending slip ticks, magnitude
   logic [6:0] beat_ff, beat_in;
   logic [6:0] beat_mod_ff, beat_mod_in;  // beat count modulo ticks per beat
   logic       clock_seen_ff, clock_seen_in;
   logic [2:0] last_keys_ff, last_keys_in;
   logic [7:0] debounce_ff, debounce_in;
   logic [7:0] led_left_ff, led_left_in;
   logic       led_level_ff, led_level_in;
   logic       busy_ff, busy_in;

   logic       rsp_valid_ff;
   logic       send_valid_ff;
   logic [7:0] send_byte_ff;
   logic       led_on_ff;

   logic       tx;
   logic [7:0] tb;
   logic [2:0] keys;
   logic [7:0] beat_next;

   assign norm_busy  = busy_ff;
   assign pop        = q_valid && !busy_ff && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = send_valid_ff;
   assign rsp_tdata  = {7'd0, led_on_ff, send_byte_ff};
   assign keys       = q_entry.data[2:0];
   assign beat_next  = {1'b0, beat_mod_ff} + 8'd1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ms_ff    <= DEBOUNCE_RESET;
         led_running_ms_ff <= LED_RUNNING_RESET;
         led_stopped_ms_ff <= LED_STOPPED_RESET;
         ticks_ff          <= TICKS_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_DEBOUNCE:    debounce_ms_ff    <= csr_wdata;
            CSR_LED_RUNNING: led_running_ms_ff <= csr_wdata;
            CSR_LED_STOPPED: led_stopped_ms_ff <= csr_wdata;
            CSR_TICKS:       ticks_ff          <= csr_wdata[6:0];
            default:         ;
         endcase
      end
   end

   always_comb begin
      running_in    = running_ff;
      slip_in       = slip_ff;
      beat_in       = beat_ff;
      beat_mod_in   = beat_mod_ff;
      clock_seen_in = clock_seen_ff;
      last_keys_in  = last_keys_ff;
      debounce_in   = debounce_ff;
      led_left_in   = led_left_ff;
      led_level_in  = led_level_ff;
      busy_in       = busy_ff;
      tx            = 1'b0;
      tb            = 8'd0;

      // bring the reduced count below a newly written ticks per beat, one subtract a cycle;
      // the visible beat count keeps its value until the next clock or start word
      if (busy_ff) begin
         if (ticks_ff != 7'd0 && beat_mod_ff >= ticks_ff) begin
            beat_mod_in = beat_mod_ff - ticks_ff;
         end else begin
            busy_in = 1'b0;
         end
      end

      if (pop) begin
         case (q_entry.kind)
            OP_CLOCK: begin
               if (running_ff) begin
                  if (slip_ff != 8'd0) begin
                     slip_in = slip_ff - 8'd1;
                  end else begin
                     tx = 1'b1;
                     tb = MIDI_CLOCK;
                  end
               end
               clock_seen_in = 1'b1;
               if (ticks_ff == 7'd0 || beat_next == {1'b0, ticks_ff}) begin
                  beat_in = 7'd0;
               end else begin
                  beat_in = beat_next[6:0];
               end
               beat_mod_in = beat_in;
            end
            OP_START: begin
               running_in  = 1'b1;
               beat_in     = 7'd0;
               beat_mod_in = 7'd0;
            end
            OP_STOP: running_in = 1'b0;
            OP_CONT: running_in = 1'b1;
            OP_PASS: begin
               tx = 1'b1;
               tb = q_entry.data;
            end
            OP_KEY: begin
               if (debounce_ff == 8'd0 && keys != last_keys_ff) begin
                  debounce_in  = debounce_ms_ff;
                  last_keys_in = keys;
                  case (keys)
                     KEY_SLIP: begin
                        if (slip_ff != SLIP_MAX) begin
                           slip_in = slip_ff + 8'd1;
                        end
                     end
                     KEY_CLOCK: begin
                        tx = 1'b1;
                        tb = MIDI_CLOCK;
                     end
                     KEY_START: begin
                        tx         = 1'b1;
                        tb         = MIDI_START;
                        running_in = 1'b1;
                     end
                     KEY_STOP: begin
                        tx         = 1'b1;
                        tb         = MIDI_STOP;
                        running_in = 1'b0;
                     end
                     KEY_CONTINUE: begin
                        tx         = 1'b1;
                        tb         = MIDI_CONTINUE;
                        running_in = 1'b1;
                     end
                     default: ;
                  endcase
               end
            end
            OP_TICK: begin
               if (debounce_ff != 8'd0) begin
                  debounce_in = debounce_ff - 8'd1;
               end
               if (led_left_ff != 8'd0) begin
                  led_left_in = led_left_ff - 8'd1;
                  if (led_left_ff == 8'd1) begin
                     led_level_in = 1'b0;
                  end
               end
            end
            default: ;
         endcase

         // beat led fires on every real item that leaves the beat at zero, once a clock word has been seen
         if (q_entry.kind != OP_NONE && clock_seen_in && beat_in == 7'd0) begin
            led_level_in = 1'b1;
            led_left_in  = running_in ? led_running_ms_ff : led_stopped_ms_ff;
         end
      end

      // a new ticks per beat restarts the reduction from the visible count
      if (csr_we && csr_index_type'(csr_addr) == CSR_TICKS) begin
         busy_in     = 1'b1;
         beat_mod_in = beat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff    <= 1'b0;
         slip_ff       <= 8'd0;
         beat_ff       <= 7'd0;
         beat_mod_ff   <= 7'd0;
         clock_seen_ff <= 1'b0;
         last_keys_ff  <= 3'd0;
         debounce_ff   <= 8'd0;
         led_left_ff   <= 8'd0;
         led_level_ff  <= 1'b0;
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         running_ff    <= running_in;
         slip_ff       <= slip_in;
         beat_ff       <= beat_in;
         beat_mod_ff   <= beat_mod_in;
         clock_seen_ff <= clock_seen_in;
         last_keys_ff  <= last_keys_in;
         debounce_ff   <= debounce_in;
         led_left_ff   <= led_left_in;
         led_level_ff  <= led_level_in;
         busy_ff       <= busy_in;
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         send_valid_ff <= tx;
         send_byte_ff  <= tb;
         led_on_ff     <= led_level_in;
      end
   end

   `MCNF_ASSERT_SAME(a_beat_in_range, clock, reset, !busy_ff && ticks_ff != 7'd0,
      beat_mod_ff < ticks_ff, "beat count not below ticks per beat")
   `MCNF_ASSERT_NEXT(a_no_phantom_word, clock, reset, !rsp_valid_ff && !pop,
      !rsp_valid_ff, "result word without an operation")

endmodule

`default_nettype wire

### dv/midi_clock_nudge_filter_tb.sv
// self-checking testbench for midi_clock_nudge_filter: stream driver, result monitor
// and a per-event model of the clock nudge filter; depends on mcnf_pkg and the block
`timescale 1ns / 100ps

module midi_clock_nudge_filter_tb;
   import mcnf_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   localparam logic [2:0] KEYS_RELEASED = 3'b000;
   localparam logic [2:0] KEYS_OUTER    = 3'b101;
   localparam logic [2:0] KEYS_ALL      = 3'b111;

   typedef struct packed {
      req_kind_type kind;
      logic [7:0]   rx;
      logic [2:0]   keys;
   } midi_event_type;

   typedef struct packed {
      logic       send_valid;
      logic [7:0] send_byte;
      logic       led_on;
   } nudge_out_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;  // rx_byte[7:0], key_lines[10:8]
   logic [1:0]  req_tuser = '0;  // req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;       // send_byte[7:0], led_on[8]
   logic        rsp_tuser;       // send_valid
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = '0;
   logic [7:0]  csr_wdata = '0;

   midi_clock_nudge_filter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // filter model: configuration and state
   logic [7:0]        cfg_debounce = DEBOUNCE_RESET;
   logic [7:0]        cfg_led_run  = LED_RUNNING_RESET;
   logic [7:0]        cfg_led_stop = LED_STOPPED_RESET;
   logic [6:0]        cfg_ticks    = TICKS_RESET;
   logic              run_flag = 1'b0;
   logic signed [8:0] slip_debt = '0;
   logic [6:0]        beat_pos = '0;
   logic              clock_seen = 1'b0;
   logic [2:0]        last_keys = '0;
   logic [7:0]        debounce_left = '0;
   logic [7:0]        led_left = '0;
   logic              led_level = 1'b0;

   midi_event_type event_queue[$];
   nudge_out_type  expected_out[$];
   midi_event_type cur_event;
   logic        req_taken = 1'b0;
   int          sender_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          queued = 0;
   int          bad_words = 0;
   int          cycles_run = 0;

   function automatic nudge_out_type nudge_filter_step(midi_event_type e);
      nudge_out_type r;
      int         nb;
      r = '0;
      case (e.kind)
         REQ_RX: begin
            if (e.rx == MIDI_CLOCK) begin
               if (run_flag) begin
                  // a pending slip eats the clock word and pays back one tick
                  if (slip_debt < 0) slip_debt = slip_debt + 9'sd1;
                  else begin
                     r.send_valid = 1'b1;
                     r.send_byte  = MIDI_CLOCK;
                  end
               end
               clock_seen = 1'b1;
               if (cfg_ticks == 0) beat_pos = '0;
               else begin
                  nb = (int'(beat_pos) + 1) % int'(cfg_ticks);
                  beat_pos = nb[6:0];
               end
            end else if (e.rx == MIDI_START) begin
               run_flag = 1'b1;
               beat_pos = '0;
            end else if (e.rx == MIDI_STOP) begin
               run_flag = 1'b0;
            end else if (e.rx == MIDI_CONTINUE) begin
               run_flag = 1'b1;
            end else begin
               r.send_valid = 1'b1;
               r.send_byte  = e.rx;
            end
         end
         REQ_KEY: begin
            if (debounce_left == 0 && e.keys != last_keys) begin
               debounce_left = cfg_debounce;
               last_keys = e.keys;
               case (e.keys)
                  KEY_SLIP: begin
                     if (int'(slip_debt) > -int'(SLIP_MAX)) slip_debt = slip_debt - 9'sd1;
                  end
                  KEY_CLOCK: begin
                     r.send_valid = 1'b1;
                     r.send_byte  = MIDI_CLOCK;
                  end
                  KEY_START: begin
                     r.send_valid = 1'b1;
                     r.send_byte  = MIDI_START;
                     run_flag = 1'b1;
                  end
                  KEY_STOP: begin
                     r.send_valid = 1'b1;
                     r.send_byte  = MIDI_STOP;
                     run_flag = 1'b0;
                  end
                  KEY_CONTINUE: begin
                     r.send_valid = 1'b1;
                     r.send_byte  = MIDI_CONTINUE;
                     run_flag = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         REQ_TICK: begin
            if (debounce_left != 0) debounce_left = debounce_left - 8'd1;
            if (led_left != 0) begin
               led_left = led_left - 8'd1;
               if (led_left == 0) led_level = 1'b0;
            end
         end
         default: ;
      endcase
      if (e.kind != REQ_NONE && clock_seen && beat_pos == 0) begin
         led_level = 1'b1;
         led_left = run_flag ? cfg_led_run : cfg_led_stop;
      end
      r.led_on = led_level;
      return r;
   endfunction

   // driver: inputs change on the falling edge
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_taken)) begin
         if (event_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            cur_event = event_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {5'b0, cur_event.keys, cur_event.rx};
            req_tuser  <= cur_event.kind;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor: handshakes sampled on the rising edge
   always @(posedge clock) begin : watch
      nudge_out_type got;
      nudge_out_type want;
      cycles_run = cycles_run + 1;
      if (cycles_run > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) expected_out.push_back(nudge_filter_step(cur_event));
         if (rsp_tvalid && rsp_tready) begin
            got.send_valid = rsp_tuser;
            got.send_byte  = rsp_tdata[7:0];
            got.led_on     = rsp_tdata[8];
            if (expected_out.size() == 0) begin
               $error("result word with nothing expected: send_valid %0d send_byte %02h led_on %0d",
                      got.send_valid, got.send_byte, got.led_on);
               bad_words++;
            end else begin
               want = expected_out.pop_front();
               if (got.send_valid !== want.send_valid) begin
                  $error("send_valid mismatch: expected %0d, actual %0d",
                         want.send_valid, got.send_valid);
                  bad_words++;
               end
               if (got.send_byte !== want.send_byte) begin
                  $error("send_byte mismatch: expected %02h, actual %02h",
                         want.send_byte, got.send_byte);
                  bad_words++;
               end
               if (got.led_on !== want.led_on) begin
                  $error("led_on mismatch: expected %0d, actual %0d", want.led_on, got.led_on);
                  bad_words++;
               end
            end
         end
      end
   end

   task automatic push_event(req_kind_type k, logic [7:0] rx, logic [2:0] keys);
      midi_event_type e;
      e.kind = k;
      e.rx   = rx;
      e.keys = keys;
      event_queue.push_back(e);
      queued++;
   endtask

   task automatic push_rx(logic [7:0] b);
      push_event(REQ_RX, b, 3'($urandom_range(7)));
   endtask

   task automatic push_key(logic [2:0] k);
      push_event(REQ_KEY, 8'($urandom_range(255)), k);
   endtask

   task automatic push_ticks(int n);
      repeat (n) push_event(REQ_TICK, 8'($urandom_range(255)), 3'($urandom_range(7)));
   endtask

   function automatic logic [7:0] rt_byte();
      case ($urandom_range(4))
         0, 1: return MIDI_CLOCK;
         2: return MIDI_START;
         3: return MIDI_STOP;
         default: return MIDI_CONTINUE;
      endcase
   endfunction

   // mostly well-formed gestures and clock runs, some noise
   task automatic queue_random(int n);
      int         stop_at;
      int         len;
      int         tick_max;
      logic [2:0] k;
      stop_at = queued + n;
      tick_max = (cfg_debounce > 38) ? 40 : int'(cfg_debounce) + 2;
      while (queued < stop_at) begin
         case ($urandom_range(9))
            0, 1: begin
               if ($urandom_range(4) == 0) k = 3'($urandom_range(7));
               else begin
                  case ($urandom_range(4))
                     0: k = KEY_CONTINUE;
                     1: k = KEY_SLIP;
                     2: k = KEY_CLOCK;
                     3: k = KEY_STOP;
                     default: k = KEY_START;
                  endcase
               end
               push_key(k);
               push_ticks($urandom_range(tick_max));
               if ($urandom_range(3) != 0) begin
                  push_key(KEYS_RELEASED);
                  push_ticks($urandom_range(tick_max));
               end
            end
            2, 3, 4: begin
               if ($urandom_range(2) == 0) push_rx($urandom_range(1) ? MIDI_START : MIDI_CONTINUE);
               len = $urandom_range(1, 40);
               repeat (len) begin
                  if ($urandom_range(9) == 0) push_rx(8'($urandom_range(255)));
                  else if ($urandom_range(9) == 0) push_ticks(1);
                  push_rx(MIDI_CLOCK);
               end
            end
            5: push_rx(rt_byte());
            6: push_ticks($urandom_range(1, 60));
            7: begin
               repeat ($urandom_range(1, 5))
                  push_event(req_kind_type'($urandom_range(3)), 8'($urandom_range(255)),
                             3'($urandom_range(7)));
            end
            8: begin
               push_rx(MIDI_STOP);
               repeat ($urandom_range(1, 6)) push_rx(MIDI_CLOCK);
            end
            default: repeat ($urandom_range(1, 4)) push_rx(8'($urandom_range(255)));
         endcase
      end
   endtask

   // hold until the block has nothing in flight
   task automatic drain();
      @(posedge clock);
      while (event_queue.size() != 0 || req_tvalid || expected_out.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [7:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_DEBOUNCE:    cfg_debounce = val;
         CSR_LED_RUNNING: cfg_led_run = val;
         CSR_LED_STOPPED: cfg_led_stop = val;
         default:         cfg_ticks = val[6:0];
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_phase(logic [7:0] deb, logic [7:0] lrun, logic [7:0] lstop,
                            logic [7:0] tpb);
      drain();
      repeat (6) @(posedge clock);
      write_reg(CSR_DEBOUNCE, deb);
      write_reg(CSR_LED_RUNNING, lrun);
      write_reg(CSR_LED_STOPPED, lstop);
      write_reg(CSR_TICKS, tpb);
   endtask

   task automatic run_random(int sender, int recv, int n);
      sender_idle_pct = sender;
      recv_stall_pct = recv;
      queue_random(n / 2);
      drain();
      queue_random(n - n / 2);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: pass-through, realtime words, slip payback, every key code
      set_phase(8'd0, LED_RUNNING_RESET, LED_STOPPED_RESET, 8'(TICKS_RESET));
      push_rx(8'h00);
      push_rx(8'hff);
      push_rx(8'h7f);
      push_rx(MIDI_CLOCK);
      push_rx(MIDI_START);
      push_rx(MIDI_CLOCK);
      push_key(KEY_SLIP);
      push_key(KEYS_RELEASED);
      push_key(KEY_SLIP);
      repeat (3) push_rx(MIDI_CLOCK);
      push_key(KEY_CLOCK);
      push_key(KEY_START);
      push_key(KEY_STOP);
      push_key(KEY_CONTINUE);
      push_key(KEYS_ALL);
      push_key(KEYS_OUTER);
      push_key(KEYS_RELEASED);
      push_rx(MIDI_STOP);
      push_rx(MIDI_CONTINUE);
      push_event(REQ_NONE, 8'hff, KEYS_ALL);
      push_ticks(3);

      // drive the slip count into its floor, then let clock words pay some back
      set_phase(8'd0, 8'd10, 8'd4, 8'd7);
      sender_idle_pct = 17;
      recv_stall_pct = 17;
      repeat (256) begin
         push_key(KEY_SLIP);
         case ($urandom_range(2))
            0: push_key(KEYS_RELEASED);
            1: push_key(KEYS_OUTER);
            default: push_key(KEYS_ALL);
         endcase
      end
      push_rx(MIDI_START);
      repeat (10) push_rx(MIDI_CLOCK);
      push_ticks(4);

      // one beat per clock word, zero hold while stopped
      set_phase(8'd2, 8'd5, 8'd0, 8'd1);
      run_random(0, 0, 16);

      set_phase(8'd20, 8'd255, 8'd1, 8'd96);
      run_random(57, 0, 16);

      set_phase(8'd0, 8'd0, 8'd255, 8'd3);
      run_random(0, 57, 16);

      set_phase(8'd255, 8'd3, 8'd2, 8'd24);
      run_random(17, 17, 16);

      drain();
      repeat (10) @(posedge clock);
      if (bad_words == 0 && expected_out.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+sv
sv/mcnf_pkg.sv
sv/mcnf_front.sv
sv/mcnf_queue.sv
sv/mcnf_back.sv
sv/midi_clock_nudge_filter.sv
dv/midi_clock_nudge_filter_tb.sv
